// ===== design/hse_pkg.sv =====
`default_nettype none
package hse_pkg;

    localparam int IN_W  = 32;
    localparam int OUT_W = 32;
    localparam int EXT_W = 64;

    localparam int ST_W = 4;
    typedef logic [ST_W-1:0] state_t;

    localparam state_t ST_COLLECT  = 4'd0;
    localparam state_t ST_BLD_RD   = 4'd1;
    localparam state_t ST_BLD_LD   = 4'd2;
    localparam state_t ST_SIFT_RD  = 4'd3;
    localparam state_t ST_SIFT_C1  = 4'd4;
    localparam state_t ST_SIFT_C2  = 4'd5;
    localparam state_t ST_SIFT_END = 4'd6;
    localparam state_t ST_EXT_RD   = 4'd7;
    localparam state_t ST_EXT_LD   = 4'd8;
    localparam state_t ST_OUT_RD   = 4'd9;
    localparam state_t ST_OUT_SHOW = 4'd10;

endpackage
`default_nettype wire

// ===== design/hse_store.sv =====
`default_nettype none
module hse_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re_a,
    input  wire logic [AW-1:0]    raddr_a,
    output logic      [WIDTH-1:0] rdata_a,
    input  wire logic             re_b,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read on that port
    always_ff @(posedge clk)
    begin
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule
`default_nettype wire

// ===== design/heap_sort_engine_core.sv =====
`default_nettype none
// values are stored one per cycle while collecting; after the last one each sift of the
// in-place heap sort loads its value, then per level reads both children, compares them and
// moves the larger child up, and ends by writing the value back; each sorted value is then read
// and presented; one set at a time, the single compare unit and the two-read store set the pace
// reset: state and item count clear at once, input is ready and output valid drops; store contents stay undefined
module heap_sort_engine_core #(
    parameter int MAX_ITEMS  = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [hse_pkg::IN_W-1:0] s_axis_tdata,  // [31:0] value
    input  wire logic                     s_axis_tlast,  // is_last
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [hse_pkg::OUT_W-1:0]     m_axis_tdata,  // [31:0] sorted_value
    output logic                          m_axis_tlast   // end_of_run
);

    import hse_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int IW = AW + 2;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [CW-1:0]   len_reg, len_next;
    logic [CW-1:0]   bld_reg, bld_next;
    logic [CW-1:0]   ext_reg, ext_next;
    logic [AW-1:0]   node_reg, node_next;
    logic [AW-1:0]   out_idx_reg, out_idx_next;
    logic            extract_reg, extract_next;
    logic            best_child_reg, best_child_next;
    logic [AW-1:0]   best_idx_reg, best_idx_next;
    logic [DATA_WIDTH-1:0] cur_reg, cur_next;
    logic [DATA_WIDTH-1:0] best_val_reg, best_val_next;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re_a, re_b;
    logic [AW-1:0]         raddr_a, raddr_b;
    logic [DATA_WIDTH-1:0] rd_a, rd_b;

    logic signed [EXT_W-1:0] in_ext, out_ext;
    logic [IW-1:0]   left_idx, right_idx, len_ext;
    logic [DATA_WIDTH-1:0] cmp_a, cmp_b;
    logic            gt;
    logic            room;
    logic [CW-1:0]   n_new;
    logic            take_right;

    hse_store #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (DATA_WIDTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .re_a    (re_a),
        .raddr_a (raddr_a),
        .rdata_a (rd_a),
        .re_b    (re_b),
        .raddr_b (raddr_b),
        .rdata_b (rd_b)
    );

    assign in_ext  = EXT_W'(signed'(s_axis_tdata));
    assign out_ext = EXT_W'(signed'(rd_a));

    assign left_idx  = IW'({node_reg, 1'b1});
    assign right_idx = left_idx + IW'(1);
    assign len_ext   = IW'(len_reg);

    // shared compare unit: child against current value, then right child against the winner
    assign cmp_a = (state_reg == ST_SIFT_C1) ? rd_a : rd_b;
    assign cmp_b = (state_reg == ST_SIFT_C1) ? cur_reg : best_val_reg;
    assign gt    = signed'(cmp_a) > signed'(cmp_b);

    assign room  = count_reg < CW'(MAX_ITEMS);
    assign n_new = count_reg + CW'(room);
    assign take_right = (right_idx < len_ext) && gt;

    assign s_axis_tready = (state_reg == ST_COLLECT);
    assign m_axis_tvalid = (state_reg == ST_OUT_SHOW);
    assign m_axis_tdata  = out_ext[OUT_W-1:0];
    assign m_axis_tlast  = (CW'(out_idx_reg) == n_reg - CW'(1));

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        len_next        = len_reg;
        bld_next        = bld_reg;
        ext_next        = ext_reg;
        node_next       = node_reg;
        out_idx_next    = out_idx_reg;
        extract_next    = extract_reg;
        best_child_next = best_child_reg;
        best_idx_next   = best_idx_reg;
        cur_next        = cur_reg;
        best_val_next   = best_val_reg;
        we      = 1'b0;
        waddr   = node_reg;
        wdata   = cur_reg;
        re_a    = 1'b0;
        re_b    = 1'b0;
        raddr_a = node_reg;
        raddr_b = right_idx[AW-1:0];

        case (state_reg)
            ST_COLLECT:
            begin
                if (s_axis_tvalid)
                begin
                    if (room)
                    begin
                        we    = 1'b1;
                        waddr = count_reg[AW-1:0];
                        wdata = in_ext[DATA_WIDTH-1:0];
                    end
                    count_next = n_new;
                    if (s_axis_tlast)
                    begin
                        n_next       = n_new;
                        out_idx_next = '0;
                        if (n_new < CW'(2))
                        begin
                            state_next = ST_OUT_RD;
                        end
                        else
                        begin
                            bld_next     = n_new >> 1;
                            node_next    = AW'((n_new >> 1) - CW'(1));
                            len_next     = n_new;
                            extract_next = 1'b0;
                            state_next   = ST_BLD_RD;
                        end
                    end
                end
            end
            ST_BLD_RD:
            begin
                re_a       = 1'b1;
                raddr_a    = node_reg;
                state_next = ST_BLD_LD;
            end
            ST_BLD_LD:
            begin
                cur_next   = rd_a;
                state_next = ST_SIFT_RD;
            end
            ST_SIFT_RD:
            begin
                if (left_idx < len_ext)
                begin
                    re_a       = 1'b1;
                    re_b       = 1'b1;
                    raddr_a    = left_idx[AW-1:0];
                    raddr_b    = right_idx[AW-1:0];
                    state_next = ST_SIFT_C1;
                end
                else
                begin
                    state_next = ST_SIFT_END;
                end
            end
            ST_SIFT_C1:
            begin
                best_val_next   = gt ? rd_a : cur_reg;
                best_child_next = gt;
                best_idx_next   = left_idx[AW-1:0];
                state_next      = ST_SIFT_C2;
            end
            ST_SIFT_C2:
            begin
                if (take_right || best_child_reg)
                begin
                    // larger child moves up into the hole
                    we         = 1'b1;
                    waddr      = node_reg;
                    wdata      = take_right ? rd_b : best_val_reg;
                    node_next  = take_right ? right_idx[AW-1:0] : best_idx_reg;
                    state_next = ST_SIFT_RD;
                end
                else
                begin
                    state_next = ST_SIFT_END;
                end
            end
            ST_SIFT_END:
            begin
                we    = 1'b1;
                waddr = node_reg;
                wdata = cur_reg;
                if (!extract_reg)
                begin
                    if (bld_reg == CW'(1))
                    begin
                        ext_next     = n_reg - CW'(1);
                        extract_next = 1'b1;
                        state_next   = ST_EXT_RD;
                    end
                    else
                    begin
                        bld_next   = bld_reg - CW'(1);
                        node_next  = AW'(bld_reg - CW'(2));
                        state_next = ST_BLD_RD;
                    end
                end
                else
                begin
                    if (ext_reg == CW'(1))
                    begin
                        out_idx_next = '0;
                        state_next   = ST_OUT_RD;
                    end
                    else
                    begin
                        ext_next   = ext_reg - CW'(1);
                        state_next = ST_EXT_RD;
                    end
                end
            end
            ST_EXT_RD:
            begin
                re_a       = 1'b1;
                re_b       = 1'b1;
                raddr_a    = '0;
                raddr_b    = ext_reg[AW-1:0];
                state_next = ST_EXT_LD;
            end
            ST_EXT_LD:
            begin
                // root goes to the end, the end value sifts down from the root
                we         = 1'b1;
                waddr      = ext_reg[AW-1:0];
                wdata      = rd_a;
                cur_next   = rd_b;
                node_next  = '0;
                len_next   = ext_reg;
                state_next = ST_SIFT_RD;
            end
            ST_OUT_RD:
            begin
                re_a       = 1'b1;
                raddr_a    = out_idx_reg;
                state_next = ST_OUT_SHOW;
            end
            ST_OUT_SHOW:
            begin
                if (m_axis_tready)
                begin
                    if (m_axis_tlast)
                    begin
                        count_next = '0;
                        state_next = ST_COLLECT;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + AW'(1);
                        state_next   = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_COLLECT;
            count_reg      <= '0;
            n_reg          <= '0;
            len_reg        <= '0;
            bld_reg        <= '0;
            ext_reg        <= '0;
            node_reg       <= '0;
            out_idx_reg    <= '0;
            extract_reg    <= 1'b0;
            best_child_reg <= 1'b0;
            best_idx_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            n_reg          <= n_next;
            len_reg        <= len_next;
            bld_reg        <= bld_next;
            ext_reg        <= ext_next;
            node_reg       <= node_next;
            out_idx_reg    <= out_idx_next;
            extract_reg    <= extract_next;
            best_child_reg <= best_child_next;
            best_idx_reg   <= best_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        best_val_reg <= best_val_next;
    end

endmodule
`default_nettype wire
